// ===== src/bnc_pkg.sv =====
// ----------------------------------------------------------------------------
// bnc_pkg: shared types and constants for the bracket nesting checker
// Holds the stack geometry, bracket decode, error score table and state codes.
// ----------------------------------------------------------------------------
`default_nettype none

package bnc_pkg;

  // Stack geometry
  localparam int STACK_DEPTH = 16;
  localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
  localparam int KIND_W      = 2;

  // Field widths
  localparam int SYM_W   = 8;
  localparam int ERR_W   = 15;
  localparam int COMP_W  = 38;
  localparam int TOTAL_W = 32;
  localparam int DIGIT_W = 3;

  localparam logic [COMP_W-1:0]  SCORE_MAX = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Beat kinds on the input channel
  localparam logic ACT_CHAR = 1'b0;
  localparam logic ACT_EOL  = 1'b1;

  // Bracket characters
  localparam logic [SYM_W-1:0] CH_PAREN_O = 8'h28;
  localparam logic [SYM_W-1:0] CH_PAREN_C = 8'h29;
  localparam logic [SYM_W-1:0] CH_SQUARE_O = 8'h5B;
  localparam logic [SYM_W-1:0] CH_SQUARE_C = 8'h5D;
  localparam logic [SYM_W-1:0] CH_CURLY_O = 8'h7B;
  localparam logic [SYM_W-1:0] CH_CURLY_C = 8'h7D;
  localparam logic [SYM_W-1:0] CH_ANGLE_O = 8'h3C;
  localparam logic [SYM_W-1:0] CH_ANGLE_C = 8'h3E;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_PAREN  = 2'd0;
  localparam kind_t KIND_SQUARE = 2'd1;
  localparam kind_t KIND_CURLY  = 2'd2;
  localparam kind_t KIND_ANGLE  = 2'd3;

  // Shift command for the cell chain
  typedef enum logic [1:0] {
    SH_HOLD,
    SH_PUSH,
    SH_POP
  } shift_op_t;

  typedef enum logic [1:0] {
    LS_BALANCED   = 2'd0,
    LS_INCOMPLETE = 2'd1,
    LS_CORRUPTED  = 2'd2,
    LS_OVERFLOW   = 2'd3
  } line_status_t;

  typedef enum logic {
    ST_RUN,
    ST_WALK
  } state_t;

  typedef struct packed {
    logic  is_open;
    logic  is_close;
    kind_t kind;
  } bracket_t;

  // Classify one byte
  function automatic bracket_t decode_symbol(input logic [SYM_W-1:0] sym);
    bracket_t b;
    b = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_PAREN};
    unique case (sym)
      CH_PAREN_O:  b = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_PAREN};
      CH_SQUARE_O: b = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_SQUARE};
      CH_CURLY_O:  b = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_CURLY};
      CH_ANGLE_O:  b = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_ANGLE};
      CH_PAREN_C:  b = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_PAREN};
      CH_SQUARE_C: b = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_SQUARE};
      CH_CURLY_C:  b = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_CURLY};
      CH_ANGLE_C:  b = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_ANGLE};
      default:     b = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_PAREN};
    endcase
    return b;
  endfunction

  // Score of an illegal closer
  function automatic logic [ERR_W-1:0] closer_error(input kind_t k);
    logic [ERR_W-1:0] e;
    e = '0;
    unique case (k)
      KIND_PAREN:  e = 15'd3;
      KIND_SQUARE: e = 15'd57;
      KIND_CURLY:  e = 15'd1197;
      KIND_ANGLE:  e = 15'd25137;
      default:     e = '0;
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

// ===== src/bnc_cell.sv =====
// ----------------------------------------------------------------------------
// bnc_cell: one entry of the bracket stack
// Takes the kind above it on a push, the kind below it on a pop, else holds.
// ----------------------------------------------------------------------------
`default_nettype none

module bnc_cell (
  input  wire                     clk,
  input  bnc_pkg::shift_op_t      op,
  input  bnc_pkg::kind_t          from_above,
  input  bnc_pkg::kind_t          from_below,
  output bnc_pkg::kind_t          kind_q
);
  import bnc_pkg::*;

  kind_t kind_r;
  kind_t kind_nxt;

  // Select the neighbor to load
  always_comb begin
    case (op)
      SH_PUSH: kind_nxt = from_above;
      SH_POP:  kind_nxt = from_below;
      default: kind_nxt = kind_r;
    endcase
  end

  // Hold the entry
  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
  end

  assign kind_q = kind_r;

endmodule

`default_nettype wire

// ===== src/bnc_stack.sv =====
// ----------------------------------------------------------------------------
// bnc_stack: bracket stack as a chain of shifting cells
// Cell 0 is the top; a push shifts the chain down, a pop shifts it up.
// ----------------------------------------------------------------------------
`default_nettype none

module bnc_stack (
  input  wire                     clk,
  input  bnc_pkg::shift_op_t      op,
  input  bnc_pkg::kind_t          push_kind,
  output bnc_pkg::kind_t          top_kind
);
  import bnc_pkg::*;

  kind_t cell_q     [STACK_DEPTH];
  kind_t cell_above [STACK_DEPTH];
  kind_t cell_below [STACK_DEPTH];

  genvar gi;
  generate
    for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
      // Wire neighbors, feeding the chain ends
      if (gi == 0) begin : g_top
        assign cell_above[gi] = push_kind;
      end else begin : g_mid_a
        assign cell_above[gi] = cell_q[gi-1];
      end
      if (gi == STACK_DEPTH - 1) begin : g_bot
        assign cell_below[gi] = KIND_PAREN;
      end else begin : g_mid_b
        assign cell_below[gi] = cell_q[gi+1];
      end

      bnc_cell u_cell (
        .clk        (clk),
        .op         (op),
        .from_above (cell_above[gi]),
        .from_below (cell_below[gi]),
        .kind_q     (cell_q[gi])
      );
    end
  endgenerate

  assign top_kind = cell_q[0];

endmodule

`default_nettype wire

// ===== src/bracket_nesting_checker_core.sv =====
// ----------------------------------------------------------------------------
// bracket_nesting_checker_core: balanced bracket checker, one line at a time
// Tracks open brackets per line and reports status, error and completion
// scores plus a saturating running error total at each end of line.
// ----------------------------------------------------------------------------
// Character beats are accepted back to back while the core is in its run
// state. An end of line beat moves it to a walk state that stalls the input:
// on an incomplete line the open entries leave the cell chain one per cycle
// from the top, each adding one base-5 digit to the completion score, and the
// result is then loaded into the output register once that register is free.
// The result is held in an output register, so character beats of the next
// line flow while it waits; a further end of line waits for it to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module bracket_nesting_checker_core (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire                            in_action,
  input  wire  [bnc_pkg::SYM_W-1:0]      in_symbol,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic [1:0]                     out_line_status,
  output logic [bnc_pkg::ERR_W-1:0]      out_error_score,
  output logic [bnc_pkg::COMP_W-1:0]     out_completion_score,
  output logic [bnc_pkg::TOTAL_W-1:0]    out_error_total
);
  import bnc_pkg::*;

  state_t               state_r, state_nxt;
  logic [LVL_W-1:0]     level_r, level_nxt;
  logic                 corrupt_r, corrupt_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [ERR_W-1:0]     lat_err_r, lat_err_nxt;
  logic [TOTAL_W-1:0]   total_r, total_nxt;
  line_status_t         status_r, status_nxt;
  logic [COMP_W-1:0]    comp_r, comp_nxt;

  logic                 out_valid_r, out_valid_nxt;
  line_status_t         out_status_r, out_status_nxt;
  logic [ERR_W-1:0]     out_err_r, out_err_nxt;
  logic [COMP_W-1:0]    out_comp_r, out_comp_nxt;

  shift_op_t            stack_op;
  kind_t                top_kind;
  bracket_t             br;
  logic                 in_acc;
  logic                 char_live;
  logic                 walk_pop;
  logic                 out_free;
  logic                 emit;
  logic [DIGIT_W-1:0]   digit;
  logic [COMP_W+2:0]    comp_ext;
  logic [ERR_W-1:0]     line_err;
  logic [TOTAL_W:0]     sum_ext;

  bnc_stack u_stack (
    .clk       (clk),
    .op        (stack_op),
    .push_kind (br.kind),
    .top_kind  (top_kind)
  );

  // Decode the beat and the walk condition
  assign br        = decode_symbol(in_symbol);
  assign in_acc    = in_valid && !in_stall;
  assign char_live = in_acc && (in_action == ACT_CHAR) && !corrupt_r && !ovf_r;
  assign walk_pop  = (state_r == ST_WALK) && (status_r == LS_INCOMPLETE)
                     && (level_r != '0);
  assign out_free  = !out_valid_r || !out_stall;
  assign emit      = (state_r == ST_WALK) && !walk_pop && out_free;

  // Completion digit, score * 5 + digit with saturation
  assign digit    = DIGIT_W'(top_kind) + DIGIT_W'(1);
  assign comp_ext = {3'b000, comp_r} + {1'b0, comp_r, 2'b00} + (COMP_W+3)'(digit);

  // Error score of the line and saturating total
  assign line_err = (status_r == LS_CORRUPTED) ? lat_err_r : '0;
  assign sum_ext  = {1'b0, total_r} + (TOTAL_W+1)'(line_err);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_RUN:  if (in_acc && (in_action == ACT_EOL)) state_nxt = ST_WALK;
      ST_WALK: if (emit) state_nxt = ST_RUN;
      default: state_nxt = ST_RUN;
    endcase
  end

  // Outputs of the state machine: handshake and stack command
  always_comb begin
    in_stall = 1'b1;
    stack_op = SH_HOLD;
    unique case (state_r)
      ST_RUN: begin
        in_stall = 1'b0;
        if (char_live && br.is_open && (level_r != LVL_W'(STACK_DEPTH))) begin
          stack_op = SH_PUSH;
        end else if (char_live && br.is_close && (level_r != '0)
                     && (top_kind == br.kind)) begin
          stack_op = SH_POP;
        end
      end
      ST_WALK: begin
        if (walk_pop) stack_op = SH_POP;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Line state update
  always_comb begin
    level_nxt   = level_r;
    corrupt_nxt = corrupt_r;
    ovf_nxt     = ovf_r;
    lat_err_nxt = lat_err_r;
    status_nxt  = status_r;
    comp_nxt    = comp_r;
    total_nxt   = total_r;

    if (char_live && br.is_open) begin
      if (level_r == LVL_W'(STACK_DEPTH)) ovf_nxt = 1'b1;
      else                                level_nxt = level_r + LVL_W'(1);
    end else if (char_live && br.is_close && (level_r != '0)) begin
      if (top_kind == br.kind) begin
        level_nxt = level_r - LVL_W'(1);
      end else begin
        corrupt_nxt = 1'b1;
        lat_err_nxt = closer_error(br.kind);
      end
    end

    // Capture the status at end of line
    if (in_acc && (in_action == ACT_EOL)) begin
      comp_nxt = '0;
      if (corrupt_r)            status_nxt = LS_CORRUPTED;
      else if (ovf_r)           status_nxt = LS_OVERFLOW;
      else if (level_r != '0)   status_nxt = LS_INCOMPLETE;
      else                      status_nxt = LS_BALANCED;
    end

    // Advance the walk one entry
    if (walk_pop) begin
      level_nxt = level_r - LVL_W'(1);
      if (comp_ext > (COMP_W+3)'(SCORE_MAX)) comp_nxt = SCORE_MAX;
      else                                   comp_nxt = comp_ext[COMP_W-1:0];
    end

    // Drop the line and update the total
    if (emit) begin
      level_nxt   = '0;
      corrupt_nxt = 1'b0;
      ovf_nxt     = 1'b0;
      lat_err_nxt = '0;
      total_nxt   = sum_ext[TOTAL_W] ? TOTAL_MAX : sum_ext[TOTAL_W-1:0];
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_err_nxt    = out_err_r;
    out_comp_nxt   = out_comp_r;
    if (emit) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = status_r;
      out_err_nxt    = line_err;
      out_comp_nxt   = comp_r;
    end else if (!out_stall) begin
      out_valid_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      level_r     <= '0;
      corrupt_r   <= 1'b0;
      ovf_r       <= 1'b0;
      lat_err_r   <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      level_r     <= level_nxt;
      corrupt_r   <= corrupt_nxt;
      ovf_r       <= ovf_nxt;
      lat_err_r   <= lat_err_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    status_r     <= status_nxt;
    comp_r       <= comp_nxt;
    out_status_r <= out_status_nxt;
    out_err_r    <= out_err_nxt;
    out_comp_r   <= out_comp_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_line_status      = out_status_r;
  assign out_error_score      = out_err_r;
  assign out_completion_score = out_comp_r;
  assign out_error_total      = total_r;

  // Checks
  a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
    !(corrupt_r && ovf_r))
    else $error("corrupted and overflow flags both set");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LVL_W'(STACK_DEPTH))
    else $error("stack level beyond depth");

  a_total_grows: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> total_r >= $past(total_r))
    else $error("error total decreased");

  a_err_only_corrupt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != LS_CORRUPTED)) |-> (out_err_r == '0))
    else $error("error score on a line that is not corrupted");

  a_walk_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    walk_pop |-> (stack_op == SH_POP) && in_stall)
    else $error("walk step without pop or with input open");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the bracket nesting checker core
// Sends lines of character beats ended by an end of line beat, predicts the
// status, scores and running error total of every line, and checks each
// result beat against the oldest predicted line. Both channels idle at random.
// ----------------------------------------------------------------------------

module tb_top;
  import bnc_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 400;
  localparam int RANDOM_BEATS   = 1800;
  localparam int CALM_FROM      = 1550;

  typedef struct {
    line_status_t         status;
    logic [ERR_W-1:0]     err;
    logic [COMP_W-1:0]    comp;
    logic [TOTAL_W-1:0]   total;
  } line_result_t;

  typedef enum {
    LINE_NESTED,
    LINE_MISMATCH,
    LINE_OVERFLOW,
    LINE_FULL,
    LINE_NOISE
  } line_shape_t;

  // Bracket tracker and store of predicted line results
  class bracket_line_scoreboard;
    kind_t                open_kinds [STACK_DEPTH];
    int                   depth;
    bit                   corrupted;
    bit                   overflowed;
    logic [ERR_W-1:0]     held_penalty;
    logic [TOTAL_W-1:0]   error_sum;
    line_result_t         pending_lines [$];
    int                   mismatches;

    function new();
      depth        = 0;
      corrupted    = 1'b0;
      overflowed   = 1'b0;
      held_penalty = '0;
      error_sum    = '0;
      mismatches   = 0;
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      mismatches++;
    endtask

    // Track one accepted input beat; predict a line result at end of line
    task note_beat(logic act, logic [SYM_W-1:0] sym);
      bit           is_op;
      bit           is_cl;
      kind_t        k;
      line_result_t r;
      logic [63:0]  acc;
      logic [63:0]  digit;
      logic [63:0]  sum;
      int           i;
      if (act == ACT_CHAR) begin
        // drop everything after corruption or overflow
        if (corrupted || overflowed) return;
        is_op = 1'b0;
        is_cl = 1'b0;
        k     = KIND_PAREN;
        case (sym)
          CH_PAREN_O:  begin is_op = 1'b1; k = KIND_PAREN;  end
          CH_SQUARE_O: begin is_op = 1'b1; k = KIND_SQUARE; end
          CH_CURLY_O:  begin is_op = 1'b1; k = KIND_CURLY;  end
          CH_ANGLE_O:  begin is_op = 1'b1; k = KIND_ANGLE;  end
          CH_PAREN_C:  begin is_cl = 1'b1; k = KIND_PAREN;  end
          CH_SQUARE_C: begin is_cl = 1'b1; k = KIND_SQUARE; end
          CH_CURLY_C:  begin is_cl = 1'b1; k = KIND_CURLY;  end
          CH_ANGLE_C:  begin is_cl = 1'b1; k = KIND_ANGLE;  end
          default: ;
        endcase
        if (is_op) begin
          if (depth >= STACK_DEPTH) begin
            overflowed = 1'b1;
          end else begin
            open_kinds[depth] = k;
            depth++;
          end
        end else if (is_cl && depth > 0) begin
          if (open_kinds[depth-1] == k) begin
            depth--;
          end else begin
            corrupted = 1'b1;
            case (k)
              KIND_PAREN:  held_penalty = 15'd3;
              KIND_SQUARE: held_penalty = 15'd57;
              KIND_CURLY:  held_penalty = 15'd1197;
              default:     held_penalty = 15'd25137;
            endcase
          end
        end
      end else begin
        r.err  = '0;
        r.comp = '0;
        if (corrupted) begin
          r.status = LS_CORRUPTED;
          r.err    = held_penalty;
        end else if (overflowed) begin
          r.status = LS_OVERFLOW;
        end else if (depth > 0) begin
          r.status = LS_INCOMPLETE;
          // walk the open brackets from the top, one base-5 digit each
          acc = '0;
          for (i = depth - 1; i >= 0; i--) begin
            digit = 64'(open_kinds[i]) + 64'd1;
            if (acc > (64'(SCORE_MAX) - digit) / 64'd5) acc = 64'(SCORE_MAX);
            else acc = acc * 64'd5 + digit;
          end
          r.comp = acc[COMP_W-1:0];
        end else begin
          r.status = LS_BALANCED;
        end
        sum = 64'(error_sum) + 64'(r.err);
        if (sum > 64'(TOTAL_MAX)) sum = 64'(TOTAL_MAX);
        error_sum = sum[TOTAL_W-1:0];
        r.total   = error_sum;
        pending_lines.insert(pending_lines.size(), r);
        depth        = 0;
        corrupted    = 1'b0;
        overflowed   = 1'b0;
        held_penalty = '0;
      end
    endtask

    // Compare one result beat with the oldest predicted line
    task check_line(logic [1:0] st, logic [ERR_W-1:0] es, logic [COMP_W-1:0] cs,
                    logic [TOTAL_W-1:0] tot);
      line_result_t want;
      if (pending_lines.size() == 0) begin
        report($sformatf("result beat with no line pending (status %0d)", st));
        return;
      end
      want = pending_lines.pop_front();
      if (st !== want.status)
        report($sformatf("line_status %0d, predicted %0d", st, want.status));
      if (es !== want.err)
        report($sformatf("error_score %0d, predicted %0d", es, want.err));
      if (cs !== want.comp)
        report($sformatf("completion_score %0d, predicted %0d", cs, want.comp));
      if (tot !== want.total)
        report($sformatf("error_total %0d, predicted %0d", tot, want.total));
    endtask
  endclass

  logic                 clk;
  logic                 rst_n       = 1'b0;
  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  logic                 in_action   = 1'b0;
  logic [SYM_W-1:0]     in_symbol   = '0;
  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  logic [1:0]           out_line_status;
  logic [ERR_W-1:0]     out_error_score;
  logic [COMP_W-1:0]    out_completion_score;
  logic [TOTAL_W-1:0]   out_error_total;

  bracket_line_scoreboard sb = new();

  bit  idle_on      = 1'b1;
  bit  hold_request = 1'b0;
  int  beats_sent   = 0;
  int  quiet_cycles = 0;

  bracket_nesting_checker_core u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_action            (in_action),
    .in_symbol            (in_symbol),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_line_status      (out_line_status),
    .out_error_score      (out_error_score),
    .out_completion_score (out_completion_score),
    .out_error_total      (out_error_total)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [SYM_W-1:0] open_char(kind_t k);
    case (k)
      KIND_PAREN:  return CH_PAREN_O;
      KIND_SQUARE: return CH_SQUARE_O;
      KIND_CURLY:  return CH_CURLY_O;
      default:     return CH_ANGLE_O;
    endcase
  endfunction

  function automatic logic [SYM_W-1:0] close_char(kind_t k);
    case (k)
      KIND_PAREN:  return CH_PAREN_C;
      KIND_SQUARE: return CH_SQUARE_C;
      KIND_CURLY:  return CH_CURLY_C;
      default:     return CH_ANGLE_C;
    endcase
  endfunction

  function automatic logic [SYM_W-1:0] any_byte();
    return SYM_W'($urandom_range(0, 255));
  endfunction

  // Offer one beat, hold it until taken, then maybe idle for a burst
  task automatic send_beat(logic act, logic [SYM_W-1:0] sym);
    in_action <= act;
    in_symbol <= sym;
    in_valid  <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic send_text_line(string s);
    int i;
    for (i = 0; i < s.len(); i++) send_beat(ACT_CHAR, s[i]);
    send_beat(ACT_EOL, any_byte());
  endtask

  // Build and send one line of the given shape, ended by end of line
  task automatic send_line(line_shape_t shape);
    kind_t shadow [$];
    kind_t k;
    int    len;
    int    i;
    int    r;
    case (shape)
      LINE_NESTED: begin
        len = $urandom_range(0, 20);
        for (i = 0; i < len; i++) begin
          r = $urandom_range(0, 9);
          if (r < 5 && shadow.size() < STACK_DEPTH) begin
            k = kind_t'($urandom_range(0, 3));
            shadow.insert(shadow.size(), k);
            send_beat(ACT_CHAR, open_char(k));
          end else if (r < 9 && shadow.size() > 0) begin
            k = shadow.pop_back();
            send_beat(ACT_CHAR, close_char(k));
          end else begin
            send_beat(ACT_CHAR, any_byte());
          end
        end
        // close out half the lines, leave the rest incomplete
        if ($urandom_range(0, 1) == 1) begin
          while (shadow.size() > 0) begin
            k = shadow.pop_back();
            send_beat(ACT_CHAR, close_char(k));
          end
        end
      end
      LINE_MISMATCH: begin
        len = $urandom_range(1, 8);
        for (i = 0; i < len; i++) begin
          k = kind_t'($urandom_range(0, 3));
          shadow.insert(shadow.size(), k);
          send_beat(ACT_CHAR, open_char(k));
        end
        k = kind_t'(shadow[$] + kind_t'($urandom_range(1, 3)));
        send_beat(ACT_CHAR, close_char(k));
        repeat ($urandom_range(0, 3)) send_beat(ACT_CHAR, any_byte());
      end
      LINE_OVERFLOW: begin
        repeat (STACK_DEPTH + 1) send_beat(ACT_CHAR, open_char(kind_t'($urandom_range(0, 3))));
        repeat ($urandom_range(0, 3)) send_beat(ACT_CHAR, any_byte());
      end
      LINE_FULL: begin
        repeat (STACK_DEPTH) send_beat(ACT_CHAR, open_char(kind_t'($urandom_range(0, 3))));
      end
      default: begin
        repeat ($urandom_range(0, 10)) send_beat(ACT_CHAR, any_byte());
      end
    endcase
    send_beat(ACT_EOL, any_byte());
  endtask

  // Receiver: random stall bursts, or one long hold on request
  initial begin
    forever begin
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        @(posedge clk);
      end
    end
  end

  // Monitor both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_line(out_line_status, out_error_score, out_completion_score,
                      out_error_total);
      if (in_valid && !in_stall) sb.note_beat(in_action, in_symbol);
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Stimulus
  initial begin
    int          line_no;
    int          r;
    line_shape_t shape;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed lines: empty line, stray closer and other bytes, each wrong
    // closer, an incomplete walk over each kind, byte extremes
    send_text_line("");
    send_text_line(")a(](");
    send_text_line("{>");
    send_text_line("[}");
    send_text_line("<)");
    send_text_line("<>([{<");
    send_beat(ACT_CHAR, 8'h00);
    send_beat(ACT_CHAR, 8'hFF);
    send_beat(ACT_EOL, 8'hFF);
    send_beat(ACT_EOL, 8'h00);

    // random lines, mostly well formed
    line_no = 0;
    while (beats_sent < RANDOM_BEATS) begin
      if (line_no == 30 || line_no == 90) hold_request = 1'b1;
      if (beats_sent >= CALM_FROM) idle_on = 1'b0;
      r = $urandom_range(0, 99);
      if (r < 55)      shape = LINE_NESTED;
      else if (r < 75) shape = LINE_MISMATCH;
      else if (r < 80) shape = LINE_OVERFLOW;
      else if (r < 86) shape = LINE_FULL;
      else             shape = LINE_NOISE;
      send_line(shape);
      line_no++;
    end
    in_valid <= 1'b0;

    // let the monitor note the last beat, drain, then let the block settle
    @(posedge clk);
    while (sb.pending_lines.size() != 0) @(posedge clk);
    repeat (STACK_DEPTH + 8) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
